// ===== hdl/swerm_pkg.sv =====
// swerm_pkg: shared types, constants and helpers of the sliding window error rate meter
// no dependencies; imported by swerm_ctrl, swerm_dp and sliding_window_error_rate_meter
package swerm_pkg;

  // sizes
  localparam int WINDOW_MAX = 4096;
  localparam int PTR_W      = $clog2(WINDOW_MAX);
  localparam int LEN_W      = PTR_W + 1;
  localparam int RATE_W     = 16;
  localparam int STEP_W     = $clog2(RATE_W);
  localparam int BYTE_W     = 8;
  localparam int APB_DW     = 32;
  localparam int APB_AW     = 2;

  localparam logic [LEN_W-1:0]  WL_RESET  = LEN_W'(1024);
  localparam logic [LEN_W-1:0]  LEN_MAX   = LEN_W'(WINDOW_MAX);
  localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(RATE_W - 1);
  localparam logic [RATE_W-1:0] RATE_SAT  = {RATE_W{1'b1}};

  // register addresses
  localparam logic [APB_AW-1:0] ADDR_WINDOW_LENGTH = APB_AW'(0);

  // input transaction
  typedef struct packed {
    logic [BYTE_W-1:0] ref_byte;
    logic [BYTE_W-1:0] rx_byte;
  } in_item_t;

  // result transaction
  typedef struct packed {
    logic [RATE_W-1:0] error_rate;
    logic [LEN_W-1:0]  error_count;
    logic              window_full;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic accept;
    logic update;
    logic div_init;
    logic div_step;
    logic out_load;
  } ctrl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic div_last;
    logic out_busy;
  } dp_stat_t;

  // zero counts as one, oversize saturates
  function automatic logic [LEN_W-1:0] eff_len(input logic [LEN_W-1:0] wl);
    logic [LEN_W-1:0] l;
    l = wl;
    if (l == '0) begin
      l = LEN_W'(1);
    end else if (l > LEN_MAX) begin
      l = LEN_MAX;
    end
    return l;
  endfunction

endpackage

// ===== hdl/swerm_ctrl.sv =====
// swerm_ctrl: per-item sequencer of the sliding window error rate meter
// depends on swerm_pkg; drives the command struct of swerm_dp
module swerm_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  item_valid,
  output logic                  item_stall,
  output swerm_pkg::ctrl_cmd_t  cmd,
  input  swerm_pkg::dp_stat_t   stat
);
  import swerm_pkg::*;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_UPDATE = 5'b00010,
    ST_PREP   = 5'b00100,
    ST_DIV    = 5'b01000,
    ST_OUT    = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // one item in flight at a time
  assign item_stall = (state != ST_IDLE);

  // next state and commands
  always_comb begin
    state_next   = state;
    cmd          = '0;
    unique case (state)
      ST_IDLE: begin
        if (item_valid) begin
          cmd.accept = 1'b1;
          state_next = ST_UPDATE;
        end
      end
      ST_UPDATE: begin
        cmd.update = 1'b1;
        state_next = ST_PREP;
      end
      ST_PREP: begin
        cmd.div_init = 1'b1;
        state_next   = ST_DIV;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
        if (stat.div_last) begin
          state_next = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!stat.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // accepted transaction always moves to the ring update
  a_accept_update: assert property (@(posedge clk) disable iff (rst)
    (item_valid && !item_stall) |=> (state == ST_UPDATE))
    else $error("accepted transaction did not reach ring update");

  // divider hands over to output once its last step is done
  a_div_to_out: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV && stat.div_last) |=> (state == ST_OUT))
    else $error("divider finish did not lead to output");

  // a result is only loaded from the output state
  a_load_from_out: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (state == ST_OUT && !stat.out_busy))
    else $error("result loaded outside output state");

endmodule

// ===== hdl/swerm_dp.sv =====
// swerm_dp: mismatch ring, running counts, restoring divider and result register
// depends on swerm_pkg; commanded by swerm_ctrl
module swerm_dp (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              clear,
  input  logic [swerm_pkg::LEN_W-1:0]       len,
  input  swerm_pkg::in_item_t               item,
  input  swerm_pkg::ctrl_cmd_t              cmd,
  output swerm_pkg::dp_stat_t               stat,
  output logic                              result_valid,
  input  logic                              result_stall,
  output swerm_pkg::out_item_t              result
);
  import swerm_pkg::*;

  logic              ring_mem [WINDOW_MAX];
  logic              ring_old;
  logic [PTR_W-1:0]  wp;
  logic [LEN_W-1:0]  fill;
  logic [LEN_W-1:0]  total;
  logic              flag;
  logic [PTR_W-1:0]  slot;
  logic [LEN_W-1:0]  rem;
  logic [RATE_W-1:0] quot;
  logic [STEP_W-1:0] step;

  logic [PTR_W-1:0]  slot_now;
  logic [LEN_W-1:0]  slot_inc;
  logic              full;
  logic [LEN_W:0]    rem_dbl;
  logic [LEN_W:0]    rem_sub;
  logic              qbit;
  logic [RATE_W-1:0] rate;

  // ring slot, wraps at the window length
  assign slot_now = ({1'b0, wp} >= len) ? '0 : wp;
  assign slot_inc = {1'b0, slot} + LEN_W'(1);
  assign full     = (fill >= len);

  // ring memory: read on accept, write on update; a slot's old value is used only once the window is full
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      ring_old <= ring_mem[slot_now];
    end
    if (cmd.update) begin
      ring_mem[slot] <= flag;
    end
  end

  // captured item
  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      flag <= (item.ref_byte != item.rx_byte);
      slot <= slot_now;
    end
  end

  // pointer, fill level and running error count
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      wp    <= '0;
      fill  <= '0;
      total <= '0;
    end else if (cmd.update) begin
      wp <= (slot_inc >= len) ? '0 : slot_inc[PTR_W-1:0];
      if (full) begin
        total <= total - LEN_W'(ring_old) + LEN_W'(flag);
      end else begin
        fill  <= fill + LEN_W'(1);
        total <= total + LEN_W'(flag);
      end
    end
  end

  // restoring divider step: (total << 16) / len
  assign rem_dbl = {rem, 1'b0};
  assign qbit    = (rem_dbl >= {1'b0, len});
  assign rem_sub = qbit ? (rem_dbl - {1'b0, len}) : rem_dbl;

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      rem  <= total;
      quot <= '0;
      step <= '0;
    end else if (cmd.div_step) begin
      rem  <= rem_sub[LEN_W-1:0];
      quot <= {quot[RATE_W-2:0], qbit};
      step <= step + STEP_W'(1);
    end
  end

  assign stat.div_last = (step == STEP_LAST);
  assign stat.out_busy = result_valid && result_stall;

  // all-error window saturates, filling window reads zero
  always_comb begin
    if (!full) begin
      rate = '0;
    end else if (total == len) begin
      rate = RATE_SAT;
    end else begin
      rate = quot;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (cmd.out_load) begin
      result_valid <= 1'b1;
    end else if (!result_stall) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      result.error_rate  <= rate;
      result.error_count <= total;
      result.window_full <= full;
    end
  end

  // running count never exceeds what the window holds
  a_total_le_fill: assert property (@(posedge clk) disable iff (rst)
    total <= fill)
    else $error("error count above fill level");

  // fill level stays within the window between clears
  a_fill_le_len: assert property (@(posedge clk) disable iff (rst || clear)
    cmd.update |=> (fill <= len))
    else $error("fill level beyond window length");

  // a waiting result is never overwritten
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> !(result_valid && result_stall))
    else $error("pending result overwritten");

endmodule

// ===== hdl/sliding_window_error_rate_meter.sv =====
// sliding_window_error_rate_meter: top level with APB register, sequencer and datapath
// depends on swerm_pkg, swerm_ctrl and swerm_dp
//
//   channel   direction  handshake                    payload
//   item      in         item_valid / item_stall      in_item_t  (ref_byte, rx_byte)
//   result    out        result_valid / result_stall  out_item_t (error_rate, error_count,
//                                                                 window_full)
//   config    in         psel / penable / pready      window_length at byte address 0
//
// one item at a time: accept, ring update, divider setup, 16 steps of the radix-2
// restoring divider, then result load once the result register is free; the next item
// is accepted the cycle after the load.
// rst (synchronous) empties the window and sets window_length to 1024; a write to
// window_length empties the window too.
// a stalled result holds the finished item until the result register frees up.
module sliding_window_error_rate_meter (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               item_valid,
  output logic                               item_stall,
  input  swerm_pkg::in_item_t                item,
  output logic                               result_valid,
  input  logic                               result_stall,
  output swerm_pkg::out_item_t               result,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [swerm_pkg::APB_AW-1:0]       paddr,
  input  logic [swerm_pkg::APB_DW-1:0]       pwdata,
  output logic [swerm_pkg::APB_DW-1:0]       prdata,
  output logic                               pready
);
  import swerm_pkg::*;

  logic [LEN_W-1:0] window_length;
  logic             wl_write;
  logic [LEN_W-1:0] len;
  ctrl_cmd_t        cmd;
  dp_stat_t         stat;

  // configuration register
  assign pready   = 1'b1;
  assign wl_write = psel && penable && pwrite && (paddr == ADDR_WINDOW_LENGTH);

  always_ff @(posedge clk) begin
    if (rst) begin
      window_length <= WL_RESET;
    end else if (wl_write) begin
      window_length <= pwdata[LEN_W-1:0];
    end
  end

  assign prdata = (paddr == ADDR_WINDOW_LENGTH) ? APB_DW'(window_length) : '0;
  assign len    = eff_len(window_length);

  // sequencer
  swerm_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .cmd        (cmd),
    .stat       (stat)
  );

  // datapath
  swerm_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .clear        (wl_write),
    .len          (len),
    .item         (item),
    .cmd          (cmd),
    .stat         (stat),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
